// ===== rtl/opaque_pixel_bounding_box_unit_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef OPAQUE_PIXEL_BOUNDING_BOX_UNIT_MACROS_SVH
`define OPAQUE_PIXEL_BOUNDING_BOX_UNIT_MACROS_SVH

// same-cycle implication
`define OPB_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("opb same-cycle check failed");

// next-cycle implication
`define OPB_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("opb next-cycle check failed");

`endif

// ===== rtl/opb_pkg.sv =====
// Shared constants for the opaque pixel bounding box unit.
// No dependencies.
`timescale 1ns / 1ps

package opb_pkg;

   localparam int MAX_DIM      = 1024;
   localparam int PALETTE_SIZE = 256;

   localparam int POS_W   = $clog2(MAX_DIM);
   localparam int DIM_W   = POS_W + 1;
   localparam int PAL_AW  = $clog2(PALETTE_SIZE);
   localparam int FMT_W   = 3;
   localparam int STAT_W  = 2;
   localparam int CSR_IW  = 2;

   localparam logic [FMT_W-1:0] PIX_RGBA16 = 3'd0;
   localparam logic [FMT_W-1:0] PIX_RGBA32 = 3'd1;
   localparam logic [FMT_W-1:0] PIX_CI4    = 3'd2;
   localparam logic [FMT_W-1:0] PIX_CI8    = 3'd3;

   localparam logic [STAT_W-1:0] STATUS_RECT  = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_UNSUP = 2'd2;

   localparam logic [CSR_IW-1:0] CSR_FORMAT = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_HEIGHT = 2'd2;

   localparam logic CMD_PALETTE = 1'b0;
   localparam logic CMD_PIXEL   = 1'b1;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd64;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd64;

endpackage

// ===== rtl/opb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module opb_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/opaque_pixel_bounding_box_unit.sv =====
// Opaque pixel bounding box unit, top level.
// Depends on opb_pkg and opb_ram.
//
// Usage:
//  - csr_* writes pixel_format (0), image_width (1), image_height (2); csr_ready is
//    always high. Write only while no pixel is in flight.
//  - req_* carries palette alpha loads (req_cmd 0) and raster-order pixels (req_cmd 1).
//    A transfer happens when req_valid is high and req_stall is low.
//  - rsp_* carries one result per image, issued for the last pixel: status,
//    offset and size of the opaque rectangle.
// A result for the last pixel reaches rsp_* via the stage 1 register, then the output register.
// Throughput: one item per cycle while req_stall is low. The palette alpha RAM is
// read in the transfer cycle, and bounds update in a single compare stage behind stage 1.
// Palette loads take effect for the very next pixel.
// Stall: while a result waits in the output register, pixels that are not
// the last of an image keep flowing; req_stall rises only when a last pixel
// must wait for the output register.
// Reset: clears the palette (via per-entry valid bits), counters, bounds and
// the output valid, and restores the registers to format 0, 64 x 64.
`timescale 1ns / 1ps

module opaque_pixel_bounding_box_unit
   import opb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_IW-1:0]  csr_index,
   input  logic [DIM_W-1:0]   csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic [PAL_AW-1:0]  req_palette_index,
   input  logic [15:0]        req_palette_entry,
   input  logic [31:0]        req_pixel_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [POS_W-1:0]   rsp_offset_x,
   output logic [POS_W-1:0]   rsp_offset_y,
   output logic [DIM_W-1:0]   rsp_size_x,
   output logic [DIM_W-1:0]   rsp_size_y
);

   typedef struct packed {
      logic             last;
      logic             use_pal;
      logic             pal_valid;
      logic             direct;
      logic             unsup;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
   } s1_type;

   logic [FMT_W-1:0]         fmt_ff, fmt_in;
   logic [DIM_W-1:0]         width_ff, width_in;
   logic [DIM_W-1:0]         height_ff, height_in;
   logic [PALETTE_SIZE-1:0]  pal_valid_ff, pal_valid_in;
   logic [POS_W-1:0]         col_ff, col_in;
   logic [POS_W-1:0]         row_ff, row_in;
   logic                     s1_valid_ff, s1_valid_in;
   s1_type                   s1_ff, s1_in;
   logic [POS_W-1:0]         min_col_ff, min_col_in;
   logic [POS_W-1:0]         max_col_ff, max_col_in;
   logic [POS_W-1:0]         min_row_ff, min_row_in;
   logic [POS_W-1:0]         max_row_ff, max_row_in;
   logic                     any_ff, any_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        status_ff, status_in;
   logic [POS_W-1:0]         off_x_ff, off_x_in;
   logic [POS_W-1:0]         off_y_ff, off_y_in;
   logic [DIM_W-1:0]         size_x_ff, size_x_in;
   logic [DIM_W-1:0]         size_y_ff, size_y_in;

   logic                     accept;
   logic                     pal_wr;
   logic                     pix_acc;
   logic                     advance;
   logic [DIM_W-1:0]         w_eff;
   logic [DIM_W-1:0]         h_eff;
   logic                     col_more;
   logic                     row_more;
   logic [PAL_AW-1:0]        rd_addr;
   logic                     ram_q;
   logic                     opaque;
   logic [POS_W-1:0]         n_min_col, n_max_col, n_min_row, n_max_row;
   logic                     n_any;

   assign csr_ready = 1'b1;

   assign advance   = !s1_valid_ff || !s1_ff.last || !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && !req_stall;
   assign pal_wr    = accept && (req_cmd == CMD_PALETTE);
   assign pix_acc   = accept && (req_cmd == CMD_PIXEL);

   opb_ram #(
      .WIDTH (1),
      .DEPTH (PALETTE_SIZE)
   ) u_pal_ram (
      .clock   (clock),
      .wr_en   (pal_wr),
      .wr_addr (req_palette_index),
      .wr_data (req_palette_entry[0]),
      .rd_en   (pix_acc),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      if (width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (width_ff > DIM_W'(MAX_DIM)) begin
         w_eff = DIM_W'(MAX_DIM);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (height_ff > DIM_W'(MAX_DIM)) begin
         h_eff = DIM_W'(MAX_DIM);
      end else begin
         h_eff = height_ff;
      end
      col_more = (DIM_W'(col_ff) + DIM_W'(1)) < w_eff;
      row_more = (DIM_W'(row_ff) + DIM_W'(1)) < h_eff;

      if (fmt_ff == PIX_CI4) begin
         rd_addr = col_ff[0] ? PAL_AW'(req_pixel_value[3:0]) : PAL_AW'(req_pixel_value[7:4]);
      end else begin
         rd_addr = req_pixel_value[PAL_AW-1:0];
      end

      opaque = s1_ff.use_pal ? (s1_ff.pal_valid && ram_q) : s1_ff.direct;
      n_min_col = (opaque && (s1_ff.col < min_col_ff)) ? s1_ff.col : min_col_ff;
      n_max_col = (opaque && (s1_ff.col > max_col_ff)) ? s1_ff.col : max_col_ff;
      n_min_row = (opaque && (s1_ff.row < min_row_ff)) ? s1_ff.row : min_row_ff;
      n_max_row = (opaque && (s1_ff.row > max_row_ff)) ? s1_ff.row : max_row_ff;
      n_any     = any_ff || opaque;
   end

   always_comb begin
      fmt_in       = fmt_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      pal_valid_in = pal_valid_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      s1_valid_in  = s1_valid_ff;
      s1_in        = s1_ff;
      min_col_in   = min_col_ff;
      max_col_in   = max_col_ff;
      min_row_in   = min_row_ff;
      max_row_in   = max_row_ff;
      any_in       = any_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      off_x_in     = off_x_ff;
      off_y_in     = off_y_ff;
      size_x_in    = size_x_ff;
      size_y_in    = size_y_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FORMAT: fmt_in    = csr_data[FMT_W-1:0];
            CSR_WIDTH:  width_in  = csr_data;
            CSR_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end

      if (pal_wr) begin
         pal_valid_in[req_palette_index] = 1'b1;
      end

      // stage 1: position and format decode at transfer
      if (advance) begin
         s1_valid_in = pix_acc;
         if (pix_acc) begin
            s1_in.col       = col_ff;
            s1_in.row       = row_ff;
            s1_in.last      = !col_more && !row_more;
            s1_in.use_pal   = (fmt_ff == PIX_CI4) || (fmt_ff == PIX_CI8);
            s1_in.pal_valid = pal_valid_ff[rd_addr];
            s1_in.unsup     = fmt_ff > PIX_CI8;
            case (fmt_ff)
               PIX_RGBA16: s1_in.direct = req_pixel_value[0];
               PIX_RGBA32: s1_in.direct = |req_pixel_value[31:24];
               default:    s1_in.direct = 1'b0;
            endcase
            if (col_more) begin
               col_in = col_ff + POS_W'(1);
            end else begin
               col_in = '0;
               row_in = row_more ? row_ff + POS_W'(1) : '0;
            end
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // stage 2: bounds update and result
      if (s1_valid_ff && advance) begin
         if (s1_ff.last) begin
            rsp_valid_in = 1'b1;
            if (s1_ff.unsup || !n_any) begin
               status_in = s1_ff.unsup ? STATUS_UNSUP : STATUS_EMPTY;
               off_x_in  = '0;
               off_y_in  = '0;
               size_x_in = '0;
               size_y_in = '0;
            end else begin
               status_in = STATUS_RECT;
               off_x_in  = n_min_col;
               off_y_in  = n_min_row;
               size_x_in = DIM_W'(n_max_col - n_min_col) + DIM_W'(1);
               size_y_in = DIM_W'(n_max_row - n_min_row) + DIM_W'(1);
            end
            min_col_in = '1;
            max_col_in = '0;
            min_row_in = '1;
            max_row_in = '0;
            any_in     = 1'b0;
         end else begin
            min_col_in = n_min_col;
            max_col_in = n_max_col;
            min_row_in = n_min_row;
            max_row_in = n_max_row;
            any_in     = n_any;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= PIX_RGBA16;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         pal_valid_ff <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         min_col_ff   <= '1;
         max_col_ff   <= '0;
         min_row_ff   <= '1;
         max_row_ff   <= '0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fmt_ff       <= fmt_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         pal_valid_ff <= pal_valid_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         min_col_ff   <= min_col_in;
         max_col_ff   <= max_col_in;
         min_row_ff   <= min_row_in;
         max_row_ff   <= max_row_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff     <= s1_in;
      status_ff <= status_in;
      off_x_ff  <= off_x_in;
      off_y_ff  <= off_y_in;
      size_x_ff <= size_x_in;
      size_y_ff <= size_y_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_offset_x = off_x_ff;
   assign rsp_offset_y = off_y_ff;
   assign rsp_size_x   = size_x_ff;
   assign rsp_size_y   = size_y_ff;

endmodule

// ===== rtl/opb_checker.sv =====
// Port-level checks for the opaque pixel bounding box unit, bound to the top level.
// Depends on opb_pkg and opaque_pixel_bounding_box_unit_macros.svh.
`timescale 1ns / 1ps
`include "opaque_pixel_bounding_box_unit_macros.svh"

module opb_checker
   import opb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_stall,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [STAT_W-1:0]  rsp_status,
   input  logic [POS_W-1:0]   rsp_offset_x,
   input  logic [POS_W-1:0]   rsp_offset_y,
   input  logic [DIM_W-1:0]   rsp_size_x,
   input  logic [DIM_W-1:0]   rsp_size_y
);

   `OPB_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid)

   `OPB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_offset_x) && $stable(rsp_size_x))

   `OPB_ASSERT_IMPLY(a_no_rect_zero, clock, reset, rsp_valid && rsp_status != STATUS_RECT, rsp_offset_x == '0 && rsp_offset_y == '0 && rsp_size_x == '0 && rsp_size_y == '0)

   `OPB_ASSERT_IMPLY(a_rect_nonempty, clock, reset, rsp_valid && rsp_status == STATUS_RECT, rsp_size_x != '0 && rsp_size_y != '0)

   `OPB_ASSERT_IMPLY(a_stall_only_on_wait, clock, reset, req_stall, rsp_valid && rsp_stall)

endmodule

bind opaque_pixel_bounding_box_unit opb_checker u_opb_checker (.*);

// ===== bench/tb_opaque_pixel_bounding_box_unit.sv =====
// Self-checking bench for opaque_pixel_bounding_box_unit: palette loads and pixel
// streams in several formats and image sizes, results checked against a local model.
// Depends on opb_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb_opaque_pixel_bounding_box_unit;
   import opb_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS  = 160;
   localparam logic [CSR_IW-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic              cmd;
      logic [PAL_AW-1:0] pal_index;
      logic [15:0]       pal_entry;
      logic [31:0]       px;
   } stim_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  off_x;
      logic [POS_W-1:0]  off_y;
      logic [DIM_W-1:0]  size_x;
      logic [DIM_W-1:0]  size_y;
   } box_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [DIM_W-1:0]  csr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_cmd = 1'b0;
   logic [PAL_AW-1:0] req_palette_index = '0;
   logic [15:0]       req_palette_entry = '0;
   logic [31:0]       req_pixel_value = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [POS_W-1:0]  rsp_offset_x;
   logic [POS_W-1:0]  rsp_offset_y;
   logic [DIM_W-1:0]  rsp_size_x;
   logic [DIM_W-1:0]  rsp_size_y;

   opaque_pixel_bounding_box_unit uut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_palette_index (req_palette_index),
      .req_palette_entry (req_palette_entry),
      .req_pixel_value   (req_pixel_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_offset_x      (rsp_offset_x),
      .rsp_offset_y      (rsp_offset_y),
      .rsp_size_x        (rsp_size_x),
      .rsp_size_y        (rsp_size_y)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Local model state
   logic [FMT_W-1:0] cfg_format = PIX_RGBA16;
   logic [DIM_W-1:0] cfg_width  = WIDTH_RESET;
   logic [DIM_W-1:0] cfg_height = HEIGHT_RESET;
   logic             pal_alpha [PALETTE_SIZE];
   logic [POS_W-1:0] col_cnt, row_cnt, min_col, max_col, min_row, max_row;
   logic             any_opaque;

   stim_type stim_items [$];
   box_type  expected_boxes [$];
   stim_type cur_item;
   int    error_count = 0;
   int    random_items = 0;
   int    pressure_requests = 0;
   bit    req_idle_en = 1'b1;
   bit    rsp_idle_en = 1'b1;

   function automatic void clear_bounds();
      col_cnt    = '0;
      row_cnt    = '0;
      min_col    = '1;
      max_col    = '0;
      min_row    = '1;
      max_row    = '0;
      any_opaque = 1'b0;
   endfunction

   function automatic int dim_in_force(logic [DIM_W-1:0] v);
      if (v == 0)
         return 1;
      if (v > MAX_DIM)
         return MAX_DIM;
      return int'(v);
   endfunction

   function automatic logic pixel_opaque(logic [31:0] px, logic [POS_W-1:0] col);
      case (cfg_format)
         PIX_RGBA16: return px[0];
         PIX_RGBA32: return px[31:24] != 8'h00;
         PIX_CI4:    return col[0] ? pal_alpha[px[3:0]] : pal_alpha[px[7:4]];
         PIX_CI8:    return pal_alpha[px[7:0]];
         default:    return 1'b0;
      endcase
   endfunction

   // Advance the model by one accepted transfer; queue a box on the last pixel.
   function automatic void track_item(stim_type it);
      box_type box;
      box = '0;
      if (it.cmd == CMD_PALETTE) begin
         pal_alpha[it.pal_index] = it.pal_entry[0];
      end else begin
         if (pixel_opaque(it.px, col_cnt)) begin
            if (col_cnt < min_col) min_col = col_cnt;
            if (col_cnt > max_col) max_col = col_cnt;
            if (row_cnt < min_row) min_row = row_cnt;
            if (row_cnt > max_row) max_row = row_cnt;
            any_opaque = 1'b1;
         end
         if (int'(col_cnt) + 1 < dim_in_force(cfg_width)) begin
            col_cnt = col_cnt + 1'b1;
         end else begin
            col_cnt = '0;
            if (int'(row_cnt) + 1 < dim_in_force(cfg_height)) begin
               row_cnt = row_cnt + 1'b1;
            end else begin
               if (cfg_format > PIX_CI8) begin
                  box.status = STATUS_UNSUP;
               end else if (!any_opaque) begin
                  box.status = STATUS_EMPTY;
               end else begin
                  box.status = STATUS_RECT;
                  box.off_x  = min_col;
                  box.off_y  = min_row;
                  box.size_x = {1'b0, max_col} - {1'b0, min_col} + 1'b1;
                  box.size_y = {1'b0, max_row} - {1'b0, min_row} + 1'b1;
               end
               expected_boxes.push_back(box);
               clear_bounds();
            end
         end
      end
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Request driver
   always @(posedge clock) begin : req_driver
      logic fire;
      int   req_gap;
      fire = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (fire) begin
            track_item(cur_item);
            req_gap = req_idle_en ? $urandom_range(0, 9) : 0;
         end
         if (req_valid && !fire) begin
            // stalled, hold the payload
         end else if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (stim_items.size() > 0) begin
            cur_item = stim_items.pop_front();
            req_valid         <= 1'b1;
            req_cmd           <= cur_item.cmd;
            req_palette_index <= cur_item.pal_index;
            req_palette_entry <= cur_item.pal_entry;
            req_pixel_value   <= cur_item.px;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor and stall generator
   always @(posedge clock) begin : rsp_monitor
      int      rsp_wait;
      int      hold_left;
      int      pressure_served;
      box_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait = 0;
         hold_left = 0;
         pressure_served = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_boxes.size() == 0) begin
               $error("result transfer with no result expected");
               error_count++;
            end else begin
               want = expected_boxes.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("offset_x", 32'(want.off_x), 32'(rsp_offset_x));
               check_field("offset_y", 32'(want.off_y), 32'(rsp_offset_y));
               check_field("size_x", 32'(want.size_x), 32'(rsp_size_x));
               check_field("size_y", 32'(want.size_y), 32'(rsp_size_y));
            end
            rsp_wait = rsp_idle_en ? $urandom_range(0, 9) : 0;
         end
         if (pressure_served != pressure_requests) begin
            pressure_served = pressure_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: cycles without any transfer
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("opaque_pixel_bounding_box_unit: mismatch");
         $finish;
      end
   end

   task automatic csr_write(input logic [CSR_IW-1:0] idx, input logic [DIM_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FORMAT: cfg_format = val[FMT_W-1:0];
         CSR_WIDTH:  cfg_width  = val;
         CSR_HEIGHT: cfg_height = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (stim_items.size() != 0 || req_valid || expected_boxes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void push_load(logic [PAL_AW-1:0] idx, logic [15:0] entry);
      stim_items.push_back('{cmd: CMD_PALETTE, pal_index: idx, pal_entry: entry,
                             px: $urandom});
   endfunction

   function automatic void push_pixel(logic [31:0] px);
      stim_items.push_back('{cmd: CMD_PIXEL, pal_index: PAL_AW'($urandom),
                             pal_entry: 16'($urandom), px: px});
   endfunction

   // RGBA16 line of n pixels, transparent except optionally first and last
   function automatic void push_line(int n, bit first_on, bit last_on);
      logic [31:0] px;
      for (int i = 0; i < n; i++) begin
         px = $urandom & 32'hFFFF_FFFE;
         if ((i == 0 && first_on) || (i == n - 1 && last_on))
            px[0] = 1'b1;
         push_pixel(px);
      end
   endfunction

   task automatic random_phase();
      int          w, h, n;
      logic [2:0]  fmt;
      logic [31:0] px;
      drain();
      req_idle_en = ($urandom_range(0, 3) != 0);
      rsp_idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) begin
         fmt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                           : 3'($urandom_range(0, 3));
         csr_write(CSR_FORMAT, {8'($urandom), fmt});
      end
      if ($urandom_range(0, 1))
         csr_write(CSR_WIDTH, DIM_W'($urandom_range(0, 8)));
      if ($urandom_range(0, 1))
         csr_write(CSR_HEIGHT, DIM_W'($urandom_range(0, 5)));
      w = dim_in_force(cfg_width);
      h = dim_in_force(cfg_height);
      n = $urandom_range(1, 3 * w * h + 2);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            push_load(PAL_AW'($urandom), 16'($urandom));
         end else begin
            case ($urandom_range(0, 3))
               0:       px = $urandom;
               1:       px = $urandom & 32'h00FF_FFFE;
               2:       px = 32'h0;
               default: px = $urandom & 32'h00FF_FF00;
            endcase
            push_pixel(px);
         end
      end
      random_items += n;
   endtask

   initial begin
      for (int i = 0; i < PALETTE_SIZE; i++)
         pal_alpha[i] = 1'b0;
      clear_bounds();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: each format, nibble selection, empty image, unsupported format
      csr_write(CSR_FORMAT, DIM_W'(PIX_RGBA16));
      csr_write(CSR_WIDTH, 11'd2);
      csr_write(CSR_HEIGHT, 11'd2);
      csr_write(CSR_SPARE, 11'h7FF);
      push_load(8'd0, 16'hFFFF);
      push_load(8'd255, 16'h0001);
      push_load(8'd1, 16'hFFFE);
      push_load(8'd15, 16'h0001);
      push_pixel(32'h0000_0000);
      push_pixel(32'hFFFF_FFFF);
      push_pixel(32'hFFFF_FFFE);
      push_pixel(32'h0000_0001);
      drain();
      csr_write(CSR_FORMAT, DIM_W'(PIX_RGBA32));
      push_pixel(32'h00FF_FFFF);
      push_pixel(32'hFF00_0000);
      push_pixel(32'h0100_0000);
      push_pixel(32'h0000_0000);
      drain();
      csr_write(CSR_FORMAT, DIM_W'(PIX_CI8));
      csr_write(CSR_WIDTH, 11'd3);
      csr_write(CSR_HEIGHT, 11'd1);
      push_pixel(32'hFFFF_FF01);
      push_pixel(32'h0000_00FF);
      push_pixel(32'h0000_0000);
      drain();
      csr_write(CSR_FORMAT, DIM_W'(PIX_CI4));
      csr_write(CSR_WIDTH, 11'd2);
      push_pixel(32'h0000_001F);
      push_pixel(32'h0000_001F);
      drain();
      csr_write(CSR_FORMAT, 11'h7FF);
      csr_write(CSR_WIDTH, 11'd1);
      push_pixel(32'hFFFF_FFFF);
      drain();
      csr_write(CSR_FORMAT, DIM_W'(PIX_RGBA16));
      push_pixel(32'h0000_0000);

      // Largest width from an oversized register value, then a zero width
      drain();
      csr_write(CSR_WIDTH, 11'h7FF);
      csr_write(CSR_HEIGHT, 11'd1);
      push_line(MAX_DIM, 1'b1, 1'b1);
      drain();
      csr_write(CSR_WIDTH, 11'd0);
      csr_write(CSR_HEIGHT, 11'd3);
      push_line(3, 1'b1, 1'b1);

      // Back-pressure: receiver holds off while one-pixel images keep coming
      drain();
      req_idle_en = 1'b0;
      csr_write(CSR_WIDTH, 11'd1);
      csr_write(CSR_HEIGHT, 11'd1);
      pressure_requests++;
      for (int i = 0; i < 40; i++)
         push_pixel($urandom);

      while (random_items < RANDOM_ITEMS)
         random_phase();

      drain();
      if (error_count == 0 && expected_boxes.size() == 0)
         $display("opaque_pixel_bounding_box_unit: match");
      else
         $display("opaque_pixel_bounding_box_unit: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/opb_pkg.sv
rtl/opb_ram.sv
rtl/opaque_pixel_bounding_box_unit.sv
rtl/opb_checker.sv
bench/tb_opaque_pixel_bounding_box_unit.sv
